// ===== sv/ecnf_pkg.sv =====
package ecnf_pkg;

    // default sensor geometry and window limit
    localparam int SENSOR_WIDTH_DEF  = 640;
    localparam int SENSOR_HEIGHT_DEF = 480;
    localparam int MAX_RADIUS_DEF    = 3;

    // field widths
    localparam int TIME_W    = 32;
    localparam int SUPPORT_W = 6;
    localparam int RADIUS_W  = 2;
    localparam int CMD_W     = 2;
    localparam int PX_W      = 10;
    localparam int PY_W      = 9;
    localparam int CFG_IDX_W = 3;

    // lanes of the shared subtract/compare unit
    localparam int LANES = 2;

    // largest window the radius register can ask for, 7 x 7
    localparam logic [SUPPORT_W-1:0] WINDOW_MAX_COUNT = 6'd49;

    // command codes
    localparam logic [CMD_W-1:0] CMD_RECORD     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REFRACTORY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEIGHBOR   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAME_GAP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPP_GAP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUPPORT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RAD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE      = 3'd4;

    // register reset values
    localparam logic [TIME_W-1:0]    SAME_GAP_RESET    = 32'd0;
    localparam logic [TIME_W-1:0]    OPP_GAP_RESET     = 32'd0;
    localparam logic [SUPPORT_W-1:0] MIN_SUPPORT_RESET = 6'd1;
    localparam logic [RADIUS_W-1:0]  RADIUS_RESET      = 2'd1;
    localparam logic [TIME_W-1:0]    MAX_AGE_RESET     = 32'd10000;

    // sequencer states
    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_SETUP  = 9'b000000100,
        ST_WRITE  = 9'b000001000,
        ST_READ   = 9'b000010000,
        ST_CHECK  = 9'b000100000,
        ST_SCAN   = 9'b001000000,
        ST_DRAIN  = 9'b010000000,
        ST_RESULT = 9'b100000000
    } state_t;

    // surface write strobes
    typedef struct packed {
        logic wr_pos;
        logic wr_neg;
    } mem_ctl_t;

    // one lane of the subtract/compare unit
    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic [TIME_W-1:0] g;
    } lane_in_t;

    typedef struct packed {
        logic [TIME_W-1:0] d;
        logic              neg;
        logic              zero;
        logic              lt;
    } lane_out_t;

endpackage

// ===== sv/ecnf_cmp.sv =====
module ecnf_cmp (
    input  ecnf_pkg::lane_in_t  [ecnf_pkg::LANES-1:0] lane_in,
    output ecnf_pkg::lane_out_t [ecnf_pkg::LANES-1:0] lane_out
);

    // wraparound difference a - b, its sign, zero and unsigned compare against g
    always_comb
    begin
        logic [ecnf_pkg::TIME_W-1:0] diff;
        diff = '0;
        for (int i = 0; i < ecnf_pkg::LANES; i++)
        begin
            diff             = lane_in[i].a - lane_in[i].b;
            lane_out[i].d    = diff;
            lane_out[i].neg  = diff[ecnf_pkg::TIME_W-1];
            lane_out[i].zero = (diff == '0);
            lane_out[i].lt   = (diff < lane_in[i].g);
        end
    end

endmodule

// ===== sv/ecnf_surface.sv =====
module ecnf_surface #(
    parameter int DEPTH = ecnf_pkg::SENSOR_WIDTH_DEF * ecnf_pkg::SENSOR_HEIGHT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  ecnf_pkg::mem_ctl_t            ctl,
    input  logic [AW-1:0]                 addr,
    input  logic [ecnf_pkg::TIME_W-1:0]   wdata,
    output logic [ecnf_pkg::TIME_W-1:0]   pos_rd,
    output logic [ecnf_pkg::TIME_W-1:0]   neg_rd
);

    logic [ecnf_pkg::TIME_W-1:0] pos_mem [DEPTH];
    logic [ecnf_pkg::TIME_W-1:0] neg_mem [DEPTH];
    logic [ecnf_pkg::TIME_W-1:0] pos_rd_reg;
    logic [ecnf_pkg::TIME_W-1:0] neg_rd_reg;

    // positive polarity timestamps, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_pos)
        begin
            pos_mem[addr] <= wdata;
        end
        pos_rd_reg <= pos_mem[addr];
    end

    // negative polarity timestamps
    always_ff @(posedge clk)
    begin
        if (ctl.wr_neg)
        begin
            neg_mem[addr] <= wdata;
        end
        neg_rd_reg <= neg_mem[addr];
    end

    assign pos_rd = pos_rd_reg;
    assign neg_rd = neg_rd_reg;

endmodule

// ===== sv/ecnf_ctrl.sv =====
module ecnf_ctrl #(
    parameter int SENSOR_WIDTH  = ecnf_pkg::SENSOR_WIDTH_DEF,
    parameter int SENSOR_HEIGHT = ecnf_pkg::SENSOR_HEIGHT_DEF,
    parameter int MAX_RADIUS    = ecnf_pkg::MAX_RADIUS_DEF,
    parameter int AW            = $clog2(SENSOR_WIDTH * SENSOR_HEIGHT)
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // request side
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic [ecnf_pkg::CMD_W-1:0]                 command,
    input  logic [ecnf_pkg::PX_W-1:0]                  pixel_x,
    input  logic [ecnf_pkg::PY_W-1:0]                  pixel_y,
    input  logic [ecnf_pkg::TIME_W-1:0]                event_time,
    input  logic                                       polarity,
    // result side
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic                                       keep,
    output logic [ecnf_pkg::SUPPORT_W-1:0]             support_count,
    // settings
    input  logic [ecnf_pkg::TIME_W-1:0]                same_gap,
    input  logic [ecnf_pkg::TIME_W-1:0]                opp_gap,
    input  logic [ecnf_pkg::SUPPORT_W-1:0]             min_support,
    input  logic [ecnf_pkg::RADIUS_W-1:0]              window_radius,
    input  logic [ecnf_pkg::TIME_W-1:0]                max_age,
    // surface memories
    output ecnf_pkg::mem_ctl_t                         mem_ctl,
    output logic [AW-1:0]                              mem_addr,
    output logic [ecnf_pkg::TIME_W-1:0]                mem_wdata,
    input  logic [ecnf_pkg::TIME_W-1:0]                pos_rd,
    input  logic [ecnf_pkg::TIME_W-1:0]                neg_rd,
    // shared subtract/compare unit
    output ecnf_pkg::lane_in_t  [ecnf_pkg::LANES-1:0]  lane_in,
    input  ecnf_pkg::lane_out_t [ecnf_pkg::LANES-1:0]  lane_out
);

    localparam int DEPTH = SENSOR_WIDTH * SENSOR_HEIGHT;
    localparam int XW    = $clog2(SENSOR_WIDTH) + 1;
    localparam int YW    = $clog2(SENSOR_HEIGHT) + 1;
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [XW-1:0] X_LAST    = XW'(SENSOR_WIDTH - 1);
    localparam logic [YW-1:0] Y_LAST    = YW'(SENSOR_HEIGHT - 1);

    ecnf_pkg::state_t state_reg, state_next;

    logic [ecnf_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic                           pol_reg, pol_next;
    logic [ecnf_pkg::TIME_W-1:0]    t_reg, t_next;
    logic [XW-1:0]                  x_lo_reg, x_lo_next;
    logic [XW-1:0]                  x_hi_reg, x_hi_next;
    logic [YW-1:0]                  y_lo_reg, y_lo_next;
    logic [YW-1:0]                  y_hi_reg, y_hi_next;
    logic [XW-1:0]                  wx_reg, wx_next;
    logic [YW-1:0]                  wy_reg, wy_next;
    logic [AW-1:0]                  addr_reg, addr_next;
    logic [AW-1:0]                  row_step_reg, row_step_next;
    logic [ecnf_pkg::TIME_W-1:0]    limit_reg, limit_next;
    logic [ecnf_pkg::SUPPORT_W-1:0] count_reg, count_next;
    logic                           keep_pre_reg, keep_pre_next;
    logic                           use_count_reg, use_count_next;
    logic                           rd_valid_reg, rd_valid_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_keep_reg, out_keep_next;
    logic [ecnf_pkg::SUPPORT_W-1:0] out_count_reg, out_count_next;

    logic          on_sensor;
    logic [RW-1:0] radius;
    logic [XW-1:0] xe, x_sum, x_lo, x_hi;
    logic [YW-1:0] ye, y_sum, y_lo, y_hi;
    logic [AW-1:0] addr_start;
    logic          newer_any;
    logic          out_free;

    assign in_stall  = (state_reg != ecnf_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign mem_addr  = addr_reg;
    assign mem_wdata = (state_reg == ecnf_pkg::ST_CLEAR) ? '0 : t_reg;

    assign out_valid     = out_valid_reg;
    assign keep          = out_keep_reg;
    assign support_count = out_count_reg;

    // window bounds of the incoming request, clipped to the sensor
    always_comb
    begin
        on_sensor = (32'(pixel_x) < 32'(SENSOR_WIDTH)) && (32'(pixel_y) < 32'(SENSOR_HEIGHT));
        if (command == ecnf_pkg::CMD_NEIGHBOR)
        begin
            if (32'(window_radius) > 32'(MAX_RADIUS))
            begin
                radius = RW'(MAX_RADIUS);
            end
            else
            begin
                radius = RW'(window_radius);
            end
        end
        else
        begin
            radius = '0;
        end
        xe    = XW'(pixel_x);
        ye    = YW'(pixel_y);
        x_lo  = (xe > XW'(radius)) ? xe - XW'(radius) : '0;
        y_lo  = (ye > YW'(radius)) ? ye - YW'(radius) : '0;
        x_sum = xe + XW'(radius);
        y_sum = ye + YW'(radius);
        x_hi  = (x_sum > X_LAST) ? X_LAST : x_sum;
        y_hi  = (y_sum > Y_LAST) ? Y_LAST : y_sum;
    end

    // first linear address of the window
    assign addr_start = AW'(32'(y_lo_reg) * 32'(SENSOR_WIDTH) + 32'(x_lo_reg));

    // recent-neighbor test on the two timestamps read last cycle
    assign newer_any = (!lane_out[0].zero && !lane_out[0].neg) ||
                       (!lane_out[1].zero && !lane_out[1].neg);

    // operand routing for the shared unit
    always_comb
    begin
        lane_in[0].a = pos_rd;
        lane_in[0].b = limit_reg;
        lane_in[0].g = '0;
        lane_in[1].a = neg_rd;
        lane_in[1].b = limit_reg;
        lane_in[1].g = '0;
        if (state_reg == ecnf_pkg::ST_SETUP)
        begin
            lane_in[0].a = t_reg;
            lane_in[0].b = max_age;
        end
        else if (state_reg == ecnf_pkg::ST_CHECK)
        begin
            lane_in[0].a = t_reg;
            lane_in[0].b = pol_reg ? pos_rd : neg_rd;
            lane_in[0].g = same_gap;
            lane_in[1].a = t_reg;
            lane_in[1].b = pol_reg ? neg_rd : pos_rd;
            lane_in[1].g = opp_gap;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pol_next       = pol_reg;
        t_next         = t_reg;
        x_lo_next      = x_lo_reg;
        x_hi_next      = x_hi_reg;
        y_lo_next      = y_lo_reg;
        y_hi_next      = y_hi_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        addr_next      = addr_reg;
        row_step_next  = row_step_reg;
        limit_next     = limit_reg;
        count_next     = count_reg;
        keep_pre_next  = keep_pre_reg;
        use_count_next = use_count_reg;
        rd_valid_next  = 1'b0;
        out_valid_next = out_valid_reg;
        out_keep_next  = out_keep_reg;
        out_count_next = out_count_reg;
        mem_ctl        = '0;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ecnf_pkg::ST_CLEAR:
            begin
                mem_ctl.wr_pos = 1'b1;
                mem_ctl.wr_neg = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ecnf_pkg::ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ecnf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = command;
                    pol_next       = polarity;
                    t_next         = event_time;
                    x_lo_next      = x_lo;
                    x_hi_next      = x_hi;
                    y_lo_next      = y_lo;
                    y_hi_next      = y_hi;
                    count_next     = '0;
                    keep_pre_next  = 1'b0;
                    use_count_next = 1'b0;
                    unique case (command)
                        ecnf_pkg::CMD_RECORD:
                        begin
                            state_next = on_sensor ? ecnf_pkg::ST_SETUP : ecnf_pkg::ST_IDLE;
                        end
                        ecnf_pkg::CMD_REFRACTORY,
                        ecnf_pkg::CMD_NEIGHBOR:
                        begin
                            state_next = on_sensor ? ecnf_pkg::ST_SETUP : ecnf_pkg::ST_RESULT;
                        end
                        default:
                        begin
                            state_next = ecnf_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ecnf_pkg::ST_SETUP:
            begin
                addr_next      = addr_start;
                row_step_next  = AW'(SENSOR_WIDTH) - AW'(x_hi_reg - x_lo_reg);
                wx_next        = x_lo_reg;
                wy_next        = y_lo_reg;
                limit_next     = lane_out[0].d;
                count_next     = '0;
                use_count_next = (cmd_reg == ecnf_pkg::CMD_NEIGHBOR);
                unique case (cmd_reg)
                    ecnf_pkg::CMD_RECORD:
                    begin
                        state_next = ecnf_pkg::ST_WRITE;
                    end
                    ecnf_pkg::CMD_REFRACTORY:
                    begin
                        state_next = ecnf_pkg::ST_READ;
                    end
                    default:
                    begin
                        state_next = ecnf_pkg::ST_SCAN;
                    end
                endcase
            end
            ecnf_pkg::ST_WRITE:
            begin
                mem_ctl.wr_pos = pol_reg;
                mem_ctl.wr_neg = !pol_reg;
                state_next     = ecnf_pkg::ST_IDLE;
            end
            ecnf_pkg::ST_READ:
            begin
                state_next = ecnf_pkg::ST_CHECK;
            end
            ecnf_pkg::ST_CHECK:
            begin
                keep_pre_next = !(lane_out[0].neg || lane_out[0].lt ||
                                  lane_out[1].neg || lane_out[1].lt);
                state_next    = ecnf_pkg::ST_RESULT;
            end
            ecnf_pkg::ST_SCAN:
            begin
                rd_valid_next = 1'b1;
                if (wx_reg == x_hi_reg)
                begin
                    if (wy_reg == y_hi_reg)
                    begin
                        state_next = ecnf_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        wx_next   = x_lo_reg;
                        wy_next   = wy_reg + 1'b1;
                        addr_next = addr_reg + row_step_reg;
                    end
                end
                else
                begin
                    wx_next   = wx_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end
            ecnf_pkg::ST_DRAIN:
            begin
                state_next = ecnf_pkg::ST_RESULT;
            end
            ecnf_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_keep_next  = use_count_reg ? (count_reg > min_support) : keep_pre_reg;
                    out_count_next = count_reg;
                    state_next     = ecnf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ecnf_pkg::ST_IDLE;
            end
        endcase

        // count each window pixel with a recent timestamp, one pixel per cycle as its timestamps arrive
        if (rd_valid_reg && newer_any)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ecnf_pkg::ST_CLEAR;
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request payload and working registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pol_reg       <= pol_next;
        t_reg         <= t_next;
        x_lo_reg      <= x_lo_next;
        x_hi_reg      <= x_hi_next;
        y_lo_reg      <= y_lo_next;
        y_hi_reg      <= y_hi_next;
        wx_reg        <= wx_next;
        wy_reg        <= wy_next;
        row_step_reg  <= row_step_next;
        limit_reg     <= limit_next;
        count_reg     <= count_next;
        keep_pre_reg  <= keep_pre_next;
        use_count_reg <= use_count_next;
        out_keep_reg  <= out_keep_next;
        out_count_reg <= out_count_next;
    end

endmodule

// ===== sv/event_camera_noise_filter.sv =====
// Event camera noise filter with refractory and neighbor-support checks.
// Request channel (in_valid / in_stall): command, pixel_x, pixel_y,
// event_time, polarity. A request is taken when in_valid is high and
// in_stall low. Record requests write event_time into the surface of
// their polarity and give no result; refractory and neighbor checks give
// one result (keep, support_count) on the out_valid / out_stall channel.
// Settings are written through cfg_we / cfg_index / cfg_data; the user
// must do so only while idle; the block does not enforce it. A record
// passes SETUP and WRITE; an off-sensor record or an unused command stays
// in IDLE; an off-sensor check goes to RESULT; a refractory check passes
// SETUP, READ, CHECK and RESULT; a neighbor check passes SETUP, SCAN,
// DRAIN and RESULT, SCAN reading the clipped window (up to 49 pixels)
// one per cycle from both timestamp memories. A result is offered in the
// same cycle as in_stall goes low. After reset a clearing pass writes
// zero to all SENSOR_WIDTH * SENSOR_HEIGHT entries (307200 by default)
// of both memories, one entry per cycle; in_stall is high meanwhile,
// settings writes are taken as usual. A finished result sits in an output
// register; while out_stall is high it holds, and the next request is
// still taken, but its result waits for the register to free up.
module event_camera_noise_filter #(
    parameter int SENSOR_WIDTH  = ecnf_pkg::SENSOR_WIDTH_DEF,
    parameter int SENSOR_HEIGHT = ecnf_pkg::SENSOR_HEIGHT_DEF,
    parameter int MAX_RADIUS    = ecnf_pkg::MAX_RADIUS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // settings port
    input  logic                              cfg_we,
    input  logic [ecnf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ecnf_pkg::TIME_W-1:0]       cfg_data,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ecnf_pkg::CMD_W-1:0]        command,
    input  logic [ecnf_pkg::PX_W-1:0]         pixel_x,
    input  logic [ecnf_pkg::PY_W-1:0]         pixel_y,
    input  logic [ecnf_pkg::TIME_W-1:0]       event_time,
    input  logic                              polarity,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              keep,
    output logic [ecnf_pkg::SUPPORT_W-1:0]    support_count
);

    localparam int DEPTH = SENSOR_WIDTH * SENSOR_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [ecnf_pkg::TIME_W-1:0]    same_gap_reg;
    logic [ecnf_pkg::TIME_W-1:0]    opp_gap_reg;
    logic [ecnf_pkg::SUPPORT_W-1:0] min_support_reg;
    logic [ecnf_pkg::RADIUS_W-1:0]  window_radius_reg;
    logic [ecnf_pkg::TIME_W-1:0]    max_age_reg;

    ecnf_pkg::mem_ctl_t                         mem_ctl;
    logic [AW-1:0]                              mem_addr;
    logic [ecnf_pkg::TIME_W-1:0]                mem_wdata;
    logic [ecnf_pkg::TIME_W-1:0]                pos_rd;
    logic [ecnf_pkg::TIME_W-1:0]                neg_rd;
    ecnf_pkg::lane_in_t  [ecnf_pkg::LANES-1:0]  lane_in;
    ecnf_pkg::lane_out_t [ecnf_pkg::LANES-1:0]  lane_out;

    // settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            same_gap_reg      <= ecnf_pkg::SAME_GAP_RESET;
            opp_gap_reg       <= ecnf_pkg::OPP_GAP_RESET;
            min_support_reg   <= ecnf_pkg::MIN_SUPPORT_RESET;
            window_radius_reg <= ecnf_pkg::RADIUS_RESET;
            max_age_reg       <= ecnf_pkg::MAX_AGE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ecnf_pkg::CFG_SAME_GAP:    same_gap_reg      <= cfg_data;
                ecnf_pkg::CFG_OPP_GAP:     opp_gap_reg       <= cfg_data;
                ecnf_pkg::CFG_MIN_SUPPORT: min_support_reg   <= cfg_data[ecnf_pkg::SUPPORT_W-1:0];
                ecnf_pkg::CFG_WINDOW_RAD:  window_radius_reg <= cfg_data[ecnf_pkg::RADIUS_W-1:0];
                ecnf_pkg::CFG_MAX_AGE:     max_age_reg       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // sequencer
    ecnf_ctrl #(
        .SENSOR_WIDTH  (SENSOR_WIDTH),
        .SENSOR_HEIGHT (SENSOR_HEIGHT),
        .MAX_RADIUS    (MAX_RADIUS),
        .AW            (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .event_time    (event_time),
        .polarity      (polarity),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .keep          (keep),
        .support_count (support_count),
        .same_gap      (same_gap_reg),
        .opp_gap       (opp_gap_reg),
        .min_support   (min_support_reg),
        .window_radius (window_radius_reg),
        .max_age       (max_age_reg),
        .mem_ctl       (mem_ctl),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .pos_rd        (pos_rd),
        .neg_rd        (neg_rd),
        .lane_in       (lane_in),
        .lane_out      (lane_out)
    );

    // timestamp surfaces
    ecnf_surface #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_surface (
        .clk    (clk),
        .ctl    (mem_ctl),
        .addr   (mem_addr),
        .wdata  (mem_wdata),
        .pos_rd (pos_rd),
        .neg_rd (neg_rd)
    );

    // shared subtract/compare unit
    ecnf_cmp u_cmp (
        .lane_in  (lane_in),
        .lane_out (lane_out)
    );

endmodule

// ===== sv/ecnf_checker.sv =====
module ecnf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             keep,
    input logic [ecnf_pkg::SUPPORT_W-1:0]   support_count
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(keep) && $stable(support_count))
        else $error("result changed while stalled");

    // the window never holds more than 7 x 7 pixels
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> support_count <= ecnf_pkg::WINDOW_MAX_COUNT)
        else $error("support count beyond window size");

    // a request never produces its result on the edge that takes it
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind event_camera_noise_filter ecnf_checker u_ecnf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .keep          (keep),
    .support_count (support_count)
);
